/* src/dep_pkg.sv */
`default_nettype none
package dep_pkg;

  localparam int CompBits   = 16;
  localparam int Stages     = 16;
  localparam int Fsh        = 32 - CompBits;
  localparam int Preshift   = 24;
  localparam int SizeBits   = 14;
  localparam int PixBits    = 13;
  localparam int AngBits    = 34;
  localparam int VecBits    = 64;
  localparam int SqBits     = 2 * CompBits + 1;
  localparam int RootBits   = (SqBits + 2 * Fsh + 1) / 2;
  localparam int SqrtSteps  = RootBits;
  localparam int StepBits   = $clog2(Stages);
  localparam int BitposBits = $clog2(RootBits);

  localparam logic [0:0] CfgWidth  = 1'b0;
  localparam logic [0:0] CfgHeight = 1'b1;

  typedef logic signed [VecBits-1:0] vec_t;
  typedef logic signed [AngBits-1:0] ang_t;

  // one stage word of the CORDIC chain
  typedef struct packed {
    logic              vld;
    vec_t              x;
    vec_t              y;
    ang_t              ang;
  } cord_t;

  // side data carried next to the CORDIC chain
  typedef struct packed {
    logic              zero;
  } side_t;

  function automatic ang_t atan_turn(input int i);
    logic [31:0] t;
    case (i)
      0:  t = 32'h20000000;  1: t = 32'h12E4051E;  2: t = 32'h09FB385B;
      3:  t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
      6:  t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
      9:  t = 32'h00145F2F; 10: t = 32'h000A2F98; 11: t = 32'h000517CC;
      12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2F9;
      15: t = 32'h0000517C; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
      18: t = 32'h00000A2F; 19: t = 32'h00000517; 20: t = 32'h0000028B;
      21: t = 32'h00000145; 22: t = 32'h000000A2; 23: t = 32'h00000051;
      24: t = 32'h00000028; 25: t = 32'h00000014; 26: t = 32'h0000000A;
      27: t = 32'h00000005; 28: t = 32'h00000002; 29: t = 32'h00000001;
      default: t = 32'h0;
    endcase
    return ang_t'({2'b00, t});
  endfunction

endpackage
`default_nettype wire

/* src/dep_sqrt_cell.sv */
`default_nettype none
// One restoring step of the integer square root: one result bit per cell.
module dep_sqrt_cell (
  input  wire logic                             clk,
  input  wire logic [dep_pkg::BitposBits-1:0]   bitpos,
  input  wire logic [2*dep_pkg::RootBits-1:0]   rem_in,
  input  wire logic [dep_pkg::RootBits-1:0]     root_in,
  output logic      [2*dep_pkg::RootBits-1:0]   rem_r,
  output logic      [dep_pkg::RootBits-1:0]     root_r
);
  import dep_pkg::*;

  logic [2*RootBits-1:0] trial;
  logic [RootBits-1:0]   cand;
  logic [2*RootBits-1:0] rem_nxt;
  logic [RootBits-1:0]   root_nxt;

  // try setting this bit: (root + 2^b)^2 - root^2 = 2*root*2^b + 4^b
  always_comb begin
    cand  = root_in | (RootBits'(1) << bitpos);
    trial = ((2*RootBits)'(root_in) << (bitpos + 1))
          | ((2*RootBits)'(1) << (2 * bitpos));
    if (rem_in >= trial) begin
      rem_nxt  = rem_in - trial;
      root_nxt = cand;
    end else begin
      rem_nxt  = rem_in;
      root_nxt = root_in;
    end
  end

  // advance one cell
  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end
endmodule
`default_nettype wire

/* src/dep_cordic_cell.sv */
`default_nettype none
// One vectoring CORDIC rotation, registered.
module dep_cordic_cell (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         en,
  input  wire logic [dep_pkg::StepBits-1:0] step,
  input  wire dep_pkg::cord_t               cin,
  output dep_pkg::cord_t                    cout_r
);
  import dep_pkg::*;

  cord_t cout_nxt;
  vec_t  dx;
  vec_t  dy;

  // rotate toward the x axis
  always_comb begin
    dx = cin.x >>> step;
    dy = cin.y >>> step;
    cout_nxt = cin;
    if (!cin.y[VecBits-1]) begin
      cout_nxt.x   = cin.x + dy;
      cout_nxt.y   = cin.y - dx;
      cout_nxt.ang = cin.ang + atan_turn(int'(step));
    end else begin
      cout_nxt.x   = cin.x - dy;
      cout_nxt.y   = cin.y + dx;
      cout_nxt.ang = cin.ang - atan_turn(int'(step));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cout_r.vld <= 1'b0;
    end else if (en) begin
      cout_r <= cout_nxt;
    end
  end
endmodule
`default_nettype wire

/* src/direction_to_equirect_pixel.sv */
`default_nettype none
// Direction to equirectangular pixel.
// in_tdata carries one direction word (x, y, z, 16-bit two's complement each);
// out_tdata carries the panorama column and row, out_tuser the zero-vector flag.
// Flow: a square-root chain of one cell per root bit forms sqrt(x^2+y^2),
// then two CORDIC chains of one cell per rotation (16) find longitude and
// polar angle, a clamp-and-scale stage registers the angles and spans, and
// the output register holds the multiplied, saturated pixels.
// Throughput: one word per clock while out_tready allows; the chain advances
// when the output register is free or being read, so a stall at out_tready
// freezes the whole chain and in_tready drops in the same cycle.
// Reset (rst_n low, synchronous) clears all valid bits and sets the size
// registers to 4096 by 2048. cfg writes take effect at once; the user must
// make them only while the pipe is empty; the block does not enforce this.
module direction_to_equirect_pixel (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // dir_x [15:0], dir_y [31:16], dir_z [47:32]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // pano_col [12:0], pano_row [25:13], zeros
  output logic             out_tuser,  // zero_dir
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_addr,
  input  wire logic [dep_pkg::SizeBits-1:0] cfg_wdata
);
  import dep_pkg::*;

  logic [SizeBits-1:0] width_r, height_r;
  logic                en;

  // pipeline advances when the output slot is free or drained
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SizeBits'(4096);
      height_r <= SizeBits'(2048);
    end else if (cfg_we) begin
      case (cfg_addr)
        CfgWidth:  width_r  <= cfg_wdata;
        CfgHeight: height_r <= cfg_wdata;
        default:   width_r  <= width_r;
      endcase
    end
  end

  // stage 0: register inputs
  logic signed [CompBits-1:0] x0_r, y0_r, z0_r;
  logic                       v0_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_tvalid;
      x0_r <= in_tdata[15:0];
      y0_r <= in_tdata[31:16];
      z0_r <= in_tdata[47:32];
    end
  end

  // stage 1: squares
  logic [SqBits-1:0]          sq1_r;
  logic signed [CompBits-1:0] x1_r, y1_r, z1_r;
  logic                       v1_r;
  logic signed [2*CompBits-1:0] xx, yy;
  assign xx = x0_r * x0_r;
  assign yy = y0_r * y0_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r  <= v0_r;
      sq1_r <= SqBits'(unsigned'(xx)) + SqBits'(unsigned'(yy));
      x1_r  <= x0_r;
      y1_r  <= y0_r;
      z1_r  <= z0_r;
    end
  end

  // square root chain, with x, y, z and valid carried alongside
  logic [2*RootBits-1:0]      rem_c  [SqrtSteps+1];
  logic [RootBits-1:0]        root_c [SqrtSteps+1];
  logic signed [CompBits-1:0] xs_r [SqrtSteps+1];
  logic signed [CompBits-1:0] ys_r [SqrtSteps+1];
  logic signed [CompBits-1:0] zs_r [SqrtSteps+1];
  logic                       vs_r [SqrtSteps+1];

  assign rem_c[0]  = (2*RootBits)'(sq1_r) << (2 * Fsh);
  assign root_c[0] = '0;
  assign xs_r[0]   = x1_r;
  assign ys_r[0]   = y1_r;
  assign zs_r[0]   = z1_r;
  assign vs_r[0]   = v1_r;

  for (genvar g = 0; g < SqrtSteps; g++) begin : g_sqrt
    logic [2*RootBits-1:0] rem_q;
    logic [RootBits-1:0]   root_q;
    dep_sqrt_cell u_cell (
      .clk(clk), .bitpos(BitposBits'(RootBits - 1 - g)),
      .rem_in(rem_c[g]), .root_in(root_c[g]),
      .rem_r(rem_q), .root_r(root_q)
    );
    // hold the cell when stalled
    logic [2*RootBits-1:0] rem_h_r;
    logic [RootBits-1:0]   root_h_r;
    logic                  en_d_r;
    always_ff @(posedge clk) begin
      en_d_r <= en;
      if (en_d_r) begin
        rem_h_r  <= rem_q;
        root_h_r <= root_q;
      end
    end
    assign rem_c[g+1]  = en_d_r ? rem_q  : rem_h_r;
    assign root_c[g+1] = en_d_r ? root_q : root_h_r;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vs_r[g+1] <= 1'b0;
      end else if (en) begin
        vs_r[g+1] <= vs_r[g];
        xs_r[g+1] <= xs_r[g];
        ys_r[g+1] <= ys_r[g];
        zs_r[g+1] <= zs_r[g];
      end
    end
  end

  // CORDIC entry: pre-rotation into the right half plane
  cord_t lon_c [Stages+1];
  cord_t pol_c [Stages+1];
  side_t side_r [Stages+1];
  vec_t  lx, ly, px, py;
  logic  zero_s;

  always_comb begin
    lx = vec_t'(xs_r[SqrtSteps]) <<< (Fsh + Preshift);
    ly = vec_t'(ys_r[SqrtSteps]) <<< (Fsh + Preshift);
    px = vec_t'(root_c[SqrtSteps]) <<< Preshift;
    py = vec_t'(zs_r[SqrtSteps]) <<< (Fsh + Preshift);
    zero_s = (xs_r[SqrtSteps] == '0) && (ys_r[SqrtSteps] == '0)
          && (zs_r[SqrtSteps] == '0);
  end

  logic lon_zero, pol_zero;
  assign lon_zero = (lx == '0) && (ly == '0);
  assign pol_zero = (px == '0) && (py == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lon_c[0].vld <= 1'b0;
      pol_c[0].vld <= 1'b0;
    end else if (en) begin
      lon_c[0].vld <= vs_r[SqrtSteps];
      pol_c[0].vld <= vs_r[SqrtSteps];
      if (lx[VecBits-1]) begin
        lon_c[0].x   <= -lx;
        lon_c[0].y   <= -ly;
        lon_c[0].ang <= ly[VecBits-1] ? -ang_t'(64'sh80000000) : ang_t'(64'sh80000000);
      end else begin
        lon_c[0].x   <= lx;
        lon_c[0].y   <= ly;
        lon_c[0].ang <= '0;
      end
      if (py[VecBits-1]) begin
        pol_c[0].x   <= -py;
        pol_c[0].y   <= -px;
        pol_c[0].ang <= px[VecBits-1] ? -ang_t'(64'sh80000000) : ang_t'(64'sh80000000);
      end else begin
        pol_c[0].x   <= py;
        pol_c[0].y   <= px;
        pol_c[0].ang <= '0;
      end
      side_r[0].zero <= zero_s;
    end
  end

  // zero-argument flags ride with the chain
  logic za_r [Stages+1];
  logic zb_r [Stages+1];
  always_ff @(posedge clk) begin
    if (en) begin
      za_r[0] <= lon_zero;
      zb_r[0] <= pol_zero;
    end
  end

  for (genvar s = 0; s < Stages; s++) begin : g_cordic
    dep_cordic_cell u_lon (
      .clk(clk), .rst_n(rst_n), .en(en), .step(StepBits'(s)),
      .cin(lon_c[s]), .cout_r(lon_c[s+1])
    );
    dep_cordic_cell u_pol (
      .clk(clk), .rst_n(rst_n), .en(en), .step(StepBits'(s)),
      .cin(pol_c[s]), .cout_r(pol_c[s+1])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        side_r[s+1] <= side_r[s];
        za_r[s+1]   <= za_r[s];
        zb_r[s+1]   <= zb_r[s];
      end
    end
  end

  // clamp angles and form the spans
  ang_t lon_f, pol_f, u_c, p_c;
  logic [SizeBits-1:0] wspan, hspan;
  always_comb begin
    lon_f = za_r[Stages] ? '0 : lon_c[Stages].ang;
    pol_f = side_r[Stages].zero ? ang_t'(64'sh40000000)
          : (zb_r[Stages] ? '0 : pol_c[Stages].ang);
    u_c = lon_f + ang_t'(64'sh80000000);
    if (u_c[AngBits-1])                    u_c = '0;
    else if (u_c > ang_t'(64'sh100000000)) u_c = ang_t'(64'sh100000000);
    p_c = pol_f;
    if (p_c[AngBits-1])                    p_c = '0;
    else if (p_c > ang_t'(64'sh80000000))  p_c = ang_t'(64'sh80000000);
    wspan = (width_r == '0)  ? '0 : width_r - SizeBits'(1);
    hspan = (height_r == '0) ? '0 : height_r - SizeBits'(1);
  end

  logic [32:0]          um_r, pm_r;
  logic [SizeBits-1:0]  ws_r, hs_r;
  logic                 vm_r, zm_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
    end else if (en) begin
      vm_r <= lon_c[Stages].vld;
      zm_r <= side_r[Stages].zero;
      um_r <= u_c[32:0];
      pm_r <= p_c[32:0];
      ws_r <= wspan;
      hs_r <= hspan;
    end
  end

  // multiply stage
  logic [46:0] cprod, rprod;
  logic [14:0] colw, roww;
  assign cprod = 47'(um_r) * 47'(ws_r);
  assign rprod = 47'(pm_r) * 47'(hs_r);
  assign colw  = cprod[46:32];
  assign roww  = 15'(rprod[46:31]);

  logic [PixBits-1:0] col_r, row_r;
  logic               z_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (en) begin
      out_tvalid <= vm_r;
      z_r   <= zm_r;
      col_r <= (colw > 15'd8191) ? 13'h1FFF : colw[PixBits-1:0];
      row_r <= (roww > 15'd8191) ? 13'h1FFF : roww[PixBits-1:0];
    end
  end

  assign out_tdata = {6'b0, row_r, col_r};
  assign out_tuser = z_r;
endmodule
`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import dep_pkg::*;

  localparam int PipeCycles = 2 + RootBits + Stages + 2 + 8;
  localparam int StallLimit = 4000;
  localparam longint HalfTurn = 64'sd1 <<< 31;
  localparam longint FullTurn = 64'sd1 <<< 32;

  typedef struct {
    logic [PixBits-1:0] col;
    logic [PixBits-1:0] row;
    logic               zero;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [47:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic out_tuser;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_addr = CfgWidth;
  logic [SizeBits-1:0] cfg_wdata = '0;

  logic [SizeBits-1:0] width_reg = 14'd4096;
  logic [SizeBits-1:0] height_reg = 14'd2048;
  pixel_t pending_pixels[$];
  int errors = 0;
  int idle_cycles = 0;
  bit steady = 1'b0;

  direction_to_equirect_pixel i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (steady || p < 65) return 0;
    if (p < 94) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // vectoring CORDIC, angle in 2^-32 turn
  function automatic longint turn_angle(longint y, longint x);
    longint ang, dx, dy;
    ang = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      ang = (y >= 0) ? HalfTurn : -HalfTurn;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < Stages; i++) begin
      dx = x >>> i;
      dy = y >>> i;
      if (y >= 0) begin
        x += dy; y -= dx; ang += longint'(atan_turn(i));
      end else begin
        x -= dy; y += dx; ang -= longint'(atan_turn(i));
      end
    end
    return ang;
  endfunction

  function automatic pixel_t map_direction(logic signed [15:0] dx, logic signed [15:0] dy,
                                           logic signed [15:0] dz);
    pixel_t p;
    longint x, y, z, lon, polar, r, sc, u;
    longint unsigned sq, col, row, wspan, hspan;
    x = longint'(dx); y = longint'(dy); z = longint'(dz);
    p.zero = (x == 0 && y == 0 && z == 0);
    if (p.zero) begin
      lon = 0;
      polar = HalfTurn / 2;
    end else begin
      sq = longint'(x * x) + longint'(y * y);
      r = int_sqrt(sq << (2 * Fsh));
      sc = 64'sd1 <<< (Fsh + Preshift);
      lon = turn_angle(y * sc, x * sc);
      polar = turn_angle(r * (64'sd1 <<< Preshift), z * sc);
    end
    // clamp CORDIC residual
    u = lon + HalfTurn;
    if (u < 0) u = 0;
    if (u > FullTurn) u = FullTurn;
    if (polar < 0) polar = 0;
    if (polar > HalfTurn) polar = HalfTurn;
    wspan = (width_reg == 0) ? 0 : width_reg - 1;
    hspan = (height_reg == 0) ? 0 : height_reg - 1;
    col = (longint'(u) * wspan) >> 32;
    row = (longint'(polar) * hspan) >> 31;
    if (col > 8191) col = 8191;
    if (row > 8191) row = 8191;
    p.col = col[PixBits-1:0];
    p.row = row[PixBits-1:0];
    return p;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // send one direction word and queue its pixel
  task automatic send_direction(logic signed [15:0] x, logic signed [15:0] y,
                                logic signed [15:0] z);
    int g;
    g = gap_len();
    repeat (g) @(negedge clk);
    in_tdata = {z, y, x};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    pending_pixels.push_back(map_direction(x, y, z));
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  // write a size register once the pipe has drained
  task automatic write_size(logic [0:0] addr, logic [SizeBits-1:0] val);
    wait (pending_pixels.size() == 0);
    repeat (PipeCycles) @(negedge clk);
    cfg_we = 1'b1;
    cfg_addr = addr;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (addr == CfgWidth) width_reg = val;
    else height_reg = val;
  endtask

  task automatic random_direction();
    logic signed [15:0] x, y, z;
    int kind;
    x = 16'($urandom); y = 16'($urandom); z = 16'($urandom);
    kind = $urandom_range(9);
    case (kind)
      0: begin
        x = $signed(16'($urandom_range(8))) - 16'sd4;
        y = $signed(16'($urandom_range(8))) - 16'sd4;
        z = $signed(16'($urandom_range(8))) - 16'sd4;
      end
      1: begin x = 0; y = 0; end
      2: y = $signed(16'($urandom_range(6))) - 16'sd3;
      3: begin
        x = $signed(16'($urandom_range(6))) - 16'sd3;
        y = $signed(16'($urandom_range(6))) - 16'sd3;
      end
      4: z = 0;
      default: ;
    endcase
    send_direction(x, y, z);
  endtask

  task automatic test_directed();
    send_direction(0, 0, 0);
    send_direction(16'sd1, 0, 0);
    send_direction(-16'sd1, 0, 0);
    send_direction(0, 16'sd1, 0);
    send_direction(0, -16'sd1, 0);
    send_direction(0, 0, 16'sd1);
    send_direction(0, 0, -16'sd1);
    send_direction(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_direction(-16'sh8000, -16'sh8000, -16'sh8000);
    send_direction(-16'sh8000, 0, 0);
    send_direction(-16'sh8000, -16'sd1, 0);
    send_direction(-16'sh8000, 16'sd0, 16'sh7FFF);
    send_direction(16'sh7FFF, -16'sh8000, 0);
    send_direction(0, 0, -16'sh8000);
    send_direction(0, 0, 16'sh7FFF);
    send_direction(-16'sd5, 16'sd0, -16'sd3);
    send_direction(16'sh5555, -16'sh2AAB, 16'sh0F0F);
    send_direction(16'shAAAA, 16'sh5555, 16'sh00FF);
  endtask

  task automatic test_sizes(logic [SizeBits-1:0] w, logic [SizeBits-1:0] h, int n);
    write_size(CfgWidth, w);
    write_size(CfgHeight, h);
    send_direction(0, 0, 0);
    send_direction(-16'sh8000, 0, 0);
    send_direction(-16'sh8000, -16'sd1, 0);
    send_direction(0, 0, -16'sh8000);
    repeat (n) random_direction();
  endtask

  task automatic test_random_default(int n);
    repeat (n) random_direction();
  endtask

  // receiver back-pressure: hold tready low for a random gap
  initial begin
    int g;
    forever begin
      @(negedge clk);
      g = gap_len();
      if (g == 0) begin
        out_tready = 1'b1;
      end else begin
        out_tready = 1'b0;
        repeat (g - 1) @(negedge clk);
      end
    end
  end

  // check each pixel against the oldest prediction
  always @(posedge clk) begin
    pixel_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("unexpected word", out_tdata, 0);
      end else begin
        want = pending_pixels.pop_front();
        if (out_tdata[12:0] != want.col) report_mismatch("pano_col", out_tdata[12:0], want.col);
        if (out_tdata[25:13] != want.row) report_mismatch("pano_row", out_tdata[25:13], want.row);
        if (out_tuser != want.zero) report_mismatch("zero_dir", out_tuser, want.zero);
      end
    end
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_random_default(100);
    steady = 1'b1;
    test_random_default(60);
    steady = 1'b0;
    test_sizes(14'd2, 14'd2, 50);
    test_sizes(14'd8192, 14'd8192, 70);
    test_sizes(14'd16383, 14'd12000, 50);
    test_sizes(14'd0, 14'd1, 40);
    test_sizes(14'd1, 14'd0, 40);
    test_sizes(14'd1920, 14'd960, 60);
    test_sizes(14'd8191, 14'd8193, 40);
    wait (pending_pixels.size() == 0);
    repeat (PipeCycles) @(negedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* sim.f */
src/dep_pkg.sv
src/dep_sqrt_cell.sv
src/dep_cordic_cell.sv
src/direction_to_equirect_pixel.sv
dv/testbench.sv
